[hw/rtl/plm_pkg.sv]
// Package for the partition map / LBA28 command planner.
// Types, item codes and taskfile constants; no dependencies.
`timescale 1ns / 1ps

package plm_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_W     = 4;

    // request type codes
    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // result status codes
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NO_PART   = 2'd1;
    localparam logic [1:0] STS_PAST_END  = 2'd2;
    localparam logic [1:0] STS_UNALIGNED = 2'd3;

    localparam logic [8:0] TABLE_BASE  = 9'h1BE;
    localparam logic [8:0] TABLE_LIMIT = 9'h1FE;
    localparam logic [8:0] SECT_MASK   = 9'h1FF;
    localparam logic [7:0] HEAD_BASE   = 8'hE0;
    localparam logic [7:0] CMD_READ    = 8'h20;
    localparam logic [7:0] CMD_WRITE   = 8'h30;
    localparam logic [3:0] HEAD_NIBBLE = 4'hF;

    // byte positions inside a 16-byte entry
    localparam logic [3:0] POS_TYPE = 4'd4;
    localparam logic [3:0] POS_ST0  = 4'd8;
    localparam logic [3:0] POS_ST1  = 4'd9;
    localparam logic [3:0] POS_ST2  = 4'd10;
    localparam logic [3:0] POS_ST3  = 4'd11;
    localparam logic [3:0] POS_LN0  = 4'd12;
    localparam logic [3:0] POS_LN1  = 4'd13;
    localparam logic [3:0] POS_LN2  = 4'd14;
    localparam logic [3:0] POS_LN3  = 4'd15;

    typedef struct packed {
        logic [7:0]  etype;
        logic [31:0] estart;
        logic [31:0] elen;
    } t_entry;

    // request context held from accept to result
    typedef struct packed {
        logic        is_req;
        logic        is_write;
        logic        cap_en;
        logic        present;
        logic [3:0]  pos;
        logic [1:0]  disk;
        logic [2:0]  part;
        logic [30:0] off;
        logic [30:0] len;
    } t_ctx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

endpackage

[hw/rtl/plm_table.sv]
// Partition entry memory: 16 entries of type, start and length.
// Uses plm_pkg. Synchronous read, per-entry valid bits.
`timescale 1ns / 1ps

module plm_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [plm_pkg::SLOT_W-1:0]  i_rd_addr,
    output plm_pkg::t_entry             o_rd_entry,
    input  logic                        i_wr_en,
    input  logic [plm_pkg::SLOT_W-1:0]  i_wr_addr,
    input  plm_pkg::t_entry             i_wr_entry,
    output logic [plm_pkg::SLOT_COUNT-1:0] o_type_nz
);
    import plm_pkg::*;

    t_entry                r_mem [SLOT_COUNT];
    t_entry                r_rd_data;
    logic                  r_rd_vld;
    logic [SLOT_COUNT-1:0] r_vld;
    logic [SLOT_COUNT-1:0] r_nz;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_nz     <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
                r_nz[i_wr_addr]  <= (i_wr_entry.etype != 8'd0);
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_entry = r_rd_vld ? r_rd_data : '0;
    assign o_type_nz  = r_nz;

endmodule

[hw/rtl/plm_planner.sv]
// Request checker and taskfile planner: bounds check and address add,
// registered, then sector count / drive-head decode. Uses plm_pkg.
`timescale 1ns / 1ps

module plm_planner (
    input  logic            i_clk,
    input  logic            i_load,
    input  plm_pkg::t_ctx   i_ctx,
    input  plm_pkg::t_entry i_entry,
    input  logic [3:0]      i_nz,
    output logic [1:0]      o_status,
    output logic [32:0]     o_start_lba,
    output logic [22:0]     o_sector_total,
    output logic [7:0]      o_count_byte,
    output logic [8:0]      o_first_byte_offset,
    output logic            o_one_sector_steps,
    output logic            o_secondary_channel,
    output logic [7:0]      o_drive_head,
    output logic [7:0]      o_command_code
);
    import plm_pkg::*;

    logic [1:0]  r_status, n_status;
    logic [41:0] r_addr, n_addr;
    logic [30:0] r_len;
    logic        r_write;
    logic [1:0]  r_disk;

    logic [2:0]  count;
    logic [32:0] end_sum;
    logic [23:0] end_sec;

    // stage A: partition check and absolute byte address
    always_comb begin
        count   = i_ctx.present ? 3'($countones(i_nz)) : 3'd0;
        end_sum = 33'(i_ctx.off) + 33'(i_ctx.len) + 33'(SECT_MASK);
        end_sec = end_sum[32:9];
        n_status = STS_OK;
        n_addr   = 42'(i_ctx.off);
        if (i_ctx.part != 3'd0) begin
            if (i_ctx.part > 3'd4 || i_ctx.part > count) begin
                n_status = STS_NO_PART;
            end else if ({8'd0, end_sec} > i_entry.elen) begin
                n_status = STS_PAST_END;
            end else begin
                n_addr = 42'(i_ctx.off) + {1'b0, i_entry.estart, 9'd0};
            end
        end
        if (n_status == STS_OK && i_ctx.is_write &&
            (n_addr[8:0] != 9'd0 || i_ctx.len[8:0] != 9'd0)) begin
            n_status = STS_UNALIGNED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= n_status;
            r_addr   <= n_addr;
            r_len    <= i_ctx.len;
            r_write  <= i_ctx.is_write;
            r_disk   <= i_ctx.disk;
        end
    end

    // stage B: taskfile fields
    logic        unaligned;
    logic [31:0] round_sum;
    logic [22:0] total_u;
    logic [32:0] lba;

    always_comb begin
        unaligned = (r_addr[8:0] != 9'd0) || (r_len[8:0] != 9'd0);
        round_sum = 32'(r_len) + 32'(SECT_MASK);
        total_u   = (round_sum[31:9] == 23'd0) ? 23'd1 : round_sum[31:9];
        lba       = r_addr[41:9];

        o_status            = r_status;
        o_start_lba         = '0;
        o_sector_total      = '0;
        o_count_byte        = '0;
        o_first_byte_offset = '0;
        o_one_sector_steps  = 1'b0;
        o_secondary_channel = 1'b0;
        o_drive_head        = '0;
        o_command_code      = '0;
        if (r_status == STS_OK) begin
            o_start_lba = lba;
            if (unaligned) begin
                o_sector_total      = total_u;
                o_count_byte        = 8'd1;
                o_first_byte_offset = r_addr[8:0];
                o_one_sector_steps  = 1'b1;
            end else begin
                o_sector_total = {1'b0, r_len[30:9]};
                o_count_byte   = r_len[16:9];
            end
            o_secondary_channel = r_disk[1];
            o_drive_head   = HEAD_BASE | {3'd0, r_disk[0], 4'd0}
                           | {4'd0, lba[27:24] & HEAD_NIBBLE};
            o_command_code = r_write ? CMD_WRITE : CMD_READ;
        end
    end

endmodule

[hw/rtl/partition_map_lba28_command_planner.sv]
// Top level of the MBR partition map and LBA28 command planner.
// Uses plm_pkg, plm_table, plm_planner.
//
// Usage:
//   Input channel: drive the item fields and raise start; the item is taken
//   at a clock edge where start is high and busy is low. busy stays high
//   while an item is in work.
//   Boot sector byte items (type 0) update the partition entry memory by a
//   read-modify-write and give no result.
//   Read/write request items give one result: the entry is read at the
//   accept edge, checked and added in the next cycle (ST_EXEC), and the
//   result shows on the o_ ports with o_strobe high in ST_OUT, after the
//   registered memory read and the registered check stage. busy stays high
//   until then, so no new item is taken meanwhile; an unknown request type
//   gives no result.
//   Result channel: o_strobe is high for exactly one cycle per result; the
//   receiver cannot stall, so the result is taken in that cycle.
//   Reset (synchronous, active low) empties the entry table at once via
//   per-entry valid bits; no clearing pass is needed.
//   Disks at or beyond DISK_COUNT have an empty table and ignore bytes.
`timescale 1ns / 1ps

module partition_map_lba28_command_planner #(
    parameter int DISK_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_disk,
    input  logic [8:0]  i_byte_index,
    input  logic [7:0]  i_byte_value,
    input  logic [2:0]  i_partition,
    input  logic [30:0] i_byte_offset,
    input  logic [30:0] i_byte_length,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [32:0] o_start_lba,
    output logic [22:0] o_sector_total,
    output logic [7:0]  o_count_byte,
    output logic [8:0]  o_first_byte_offset,
    output logic        o_one_sector_steps,
    output logic        o_secondary_channel,
    output logic [7:0]  o_drive_head,
    output logic [7:0]  o_command_code
);
    import plm_pkg::*;

    t_state r_state, n_state;
    t_ctx   r_ctx, n_ctx;
    logic   accept;

    logic [8:0]        rel;
    logic [SLOT_W-1:0] rd_addr;
    logic [2:0]        part_m1;
    logic              in_table;

    t_entry              rd_entry;
    t_entry              wr_entry;
    logic                wr_en;
    logic [SLOT_COUNT-1:0] type_nz;

    logic [7:0]        r_byte_value;
    logic [SLOT_W-1:0] r_slot;

    assign accept = start && !busy;

    // decode the incoming item; the table address goes straight to memory
    always_comb begin
        rel      = i_byte_index - TABLE_BASE;
        part_m1  = i_partition - 3'd1;
        in_table = (i_byte_index >= TABLE_BASE) && (i_byte_index < TABLE_LIMIT);

        n_ctx.is_req   = (i_req_type == REQ_READ) || (i_req_type == REQ_WRITE);
        n_ctx.is_write = (i_req_type == REQ_WRITE);
        n_ctx.present  = (32'(i_disk) < DISK_COUNT);
        n_ctx.cap_en   = (i_req_type == REQ_BYTE) && in_table && n_ctx.present;
        n_ctx.pos      = rel[3:0];
        n_ctx.disk     = i_disk;
        n_ctx.part     = i_partition;
        n_ctx.off      = i_byte_offset;
        n_ctx.len      = i_byte_length;

        if (i_req_type == REQ_BYTE) begin
            rd_addr = {i_disk, rel[5:4]};
        end else begin
            rd_addr = {i_disk, part_m1[1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ctx <= n_ctx;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = r_ctx.is_req ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // outputs of the sequencer
    always_comb begin
        busy     = 1'b1;
        o_strobe = 1'b0;
        wr_en    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_EXEC: begin
                wr_en = r_ctx.cap_en;
            end
            ST_OUT: begin
                o_strobe = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // byte merge for the read-modify-write of one entry
    always_comb begin
        wr_entry = rd_entry;
        case (r_ctx.pos)
            POS_TYPE: wr_entry.etype         = r_byte_value;
            POS_ST0:  wr_entry.estart[7:0]   = r_byte_value;
            POS_ST1:  wr_entry.estart[15:8]  = r_byte_value;
            POS_ST2:  wr_entry.estart[23:16] = r_byte_value;
            POS_ST3:  wr_entry.estart[31:24] = r_byte_value;
            POS_LN0:  wr_entry.elen[7:0]     = r_byte_value;
            POS_LN1:  wr_entry.elen[15:8]    = r_byte_value;
            POS_LN2:  wr_entry.elen[23:16]   = r_byte_value;
            POS_LN3:  wr_entry.elen[31:24]   = r_byte_value;
            default:  wr_entry = rd_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte_value <= i_byte_value;
            r_slot       <= rd_addr;
        end
    end

    plm_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_slot),
        .i_wr_entry (wr_entry),
        .o_type_nz  (type_nz)
    );

    plm_planner u_planner (
        .i_clk               (i_clk),
        .i_load              (r_state == ST_EXEC),
        .i_ctx               (r_ctx),
        .i_entry             (rd_entry),
        .i_nz                (type_nz[{r_ctx.disk, 2'b00} +: 4]),
        .o_status            (o_status),
        .o_start_lba         (o_start_lba),
        .o_sector_total      (o_sector_total),
        .o_count_byte        (o_count_byte),
        .o_first_byte_offset (o_first_byte_offset),
        .o_one_sector_steps  (o_one_sector_steps),
        .o_secondary_channel (o_secondary_channel),
        .o_drive_head        (o_drive_head),
        .o_command_code      (o_command_code)
    );

    // a result is only shown while the block is busy with its item
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while idle");

    // every request item gives its result after accept, via ST_EXEC and ST_OUT
    a_req_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req_type == REQ_READ || i_req_type == REQ_WRITE))
            |-> ##2 o_strobe)
        else $error("request item without result");

    // byte items give no result
    a_byte_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type == REQ_BYTE) |-> ##2 !o_strobe)
        else $error("byte item produced a result");

    // an error result carries no command
    a_err_no_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != STS_OK)
            |-> (o_command_code == 8'd0 && o_start_lba == 33'd0))
        else $error("error result with command fields");

    // no table write outside a byte item
    a_write_byte_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == ST_EXEC && !r_ctx.is_req))
        else $error("table write during request");

endmodule
